>>> rtl/core/cdip_pkg.sv
// Shared types and character constants for the canonical decimal integer parser.
package cdip_pkg;

    localparam logic [7:0]  CHAR_MINUS = 8'h2D;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam int          MAG_WIDTH  = 32;
    localparam int          PROD_WIDTH = 36;
    localparam logic [MAG_WIDTH-1:0] MAG_LIMIT = 32'h8000_0000;

    // One input item: a byte of the token and the closing flag.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_char_item;

    // One result item.
    typedef struct packed {
        logic signed [31:0] value;
        logic               accepted;
    } t_result;

    // Running state of the token being parsed.
    typedef struct packed {
        logic [MAG_WIDTH-1:0] magnitude;
        logic                 negative;
        logic                 at_start;
        logic                 seen_digit;
        logic                 first_digit_zero;
        logic                 rejected;
        logic                 overflowed;
    } t_token;

    localparam t_token TOKEN_CLEAR = '{
        magnitude:        '0,
        negative:         1'b0,
        at_start:         1'b1,
        seen_digit:       1'b0,
        first_digit_zero: 1'b0,
        rejected:         1'b0,
        overflowed:       1'b0
    };

endpackage

>>> rtl/core/cdip_if.sv
// Handshake interfaces for the character input channel and the result channel.
interface cdip_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface cdip_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               accepted;

    modport source (output valid, output value, output accepted, input ready);
    modport sink   (input valid, input value, input accepted, output ready);
endinterface

>>> rtl/core/cdip_in_stage.sv
// Input register that holds one accepted character item until the parser consumes it.
module cdip_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  cdip_pkg::t_char_item i_item,
    input  logic                i_advance,
    output logic                o_ready,
    output logic                o_valid,
    output cdip_pkg::t_char_item o_item
);

    logic                 r_valid;
    logic                 n_valid;
    cdip_pkg::t_char_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign n_valid = (i_valid && o_ready) ? 1'b1 : (i_advance ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> rtl/core/cdip_token.sv
// Token state register and the per-character grammar, accumulate and range logic.
module cdip_token (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  cdip_pkg::t_char_item i_item,
    output cdip_pkg::t_result    o_result
);

    cdip_pkg::t_token r_tok;
    cdip_pkg::t_token n_tok;
    cdip_pkg::t_token upd;

    logic                                is_minus;
    logic                                is_digit;
    logic [3:0]                          digit;
    logic [cdip_pkg::PROD_WIDTH-1:0]     mag_ext;
    logic [cdip_pkg::PROD_WIDTH-1:0]     prod;
    logic                                ok;

    assign is_minus = r_tok.at_start && (i_item.char_code == cdip_pkg::CHAR_MINUS);
    assign is_digit = (i_item.char_code >= cdip_pkg::CHAR_ZERO)
                   && (i_item.char_code <= cdip_pkg::CHAR_NINE);
    assign digit    = 4'(i_item.char_code - cdip_pkg::CHAR_ZERO);
    assign mag_ext  = {{(cdip_pkg::PROD_WIDTH - cdip_pkg::MAG_WIDTH){1'b0}}, r_tok.magnitude};
    // Times ten as two shifted copies, then the new digit.
    assign prod     = (mag_ext << 3) + (mag_ext << 1)
                    + {{(cdip_pkg::PROD_WIDTH - 4){1'b0}}, digit};

    always_comb begin
        upd          = r_tok;
        upd.at_start = 1'b0;
        if (is_minus) begin
            upd.negative = 1'b1;
        end else if (is_digit) begin
            if (!r_tok.seen_digit) begin
                upd.first_digit_zero = (digit == 4'd0);
            end else if (r_tok.first_digit_zero) begin
                upd.rejected = 1'b1;
            end
            upd.seen_digit = 1'b1;
            if (!r_tok.overflowed) begin
                if (prod > {{(cdip_pkg::PROD_WIDTH - cdip_pkg::MAG_WIDTH){1'b0}},
                            cdip_pkg::MAG_LIMIT}) begin
                    upd.overflowed = 1'b1;
                end else begin
                    upd.magnitude = prod[cdip_pkg::MAG_WIDTH-1:0];
                end
            end
        end else begin
            upd.rejected = 1'b1;
        end
    end

    assign ok = !upd.rejected && !upd.overflowed && upd.seen_digit
             && !(upd.negative && upd.first_digit_zero)
             && ((upd.magnitude < cdip_pkg::MAG_LIMIT)
                 || (upd.negative && (upd.magnitude == cdip_pkg::MAG_LIMIT)));

    always_comb begin
        o_result.accepted = ok;
        if (!ok) begin
            o_result.value = '0;
        end else if (upd.negative) begin
            o_result.value = -$signed(upd.magnitude);
        end else begin
            o_result.value = $signed(upd.magnitude);
        end
    end

    always_comb begin
        if (!i_step) begin
            n_tok = r_tok;
        end else if (i_item.last_char) begin
            n_tok = cdip_pkg::TOKEN_CLEAR;
        end else begin
            n_tok = upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= cdip_pkg::TOKEN_CLEAR;
        end else begin
            r_tok <= n_tok;
        end
    end

endmodule

>>> rtl/core/cdip_result_reg.sv
// Output register that holds one finished result item until the consumer takes it.
module cdip_result_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  cdip_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output cdip_pkg::t_result o_result
);

    logic              r_valid;
    logic              n_valid;
    cdip_pkg::t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load ? 1'b1 : (i_ready ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> rtl/core/canonical_decimal_int_parser.sv
// Top level of the strict decimal string to signed 32-bit integer parser.
//
// The block reads a token one character item per cycle and, on the item that
// carries last_char, delivers exactly one result item: the signed 32-bit
// value and an accepted flag. A token is accepted only when it is the
// canonical decimal form of a value in -2147483648..2147483647, that is an
// optional leading minus followed by at least one digit, with no leading zero,
// no "-0" and no other characters; a rejected token gives the value 0.
// Items that do not close a token give no result. Throughput is one character
// item per clock cycle while the input does not stall, set by the single
// multiply-by-ten-and-add step between the input register and the token state
// register. A result is presented on the output once its closing character
// leaves the input register and the result register loads. The result
// register lets the input keep flowing while a finished result waits; the
// input stalls only when a closing character meets a result that has not
// yet been taken.
module canonical_decimal_int_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cdip_char_if.sink         i_char,
    cdip_result_if.source     o_result
);

    cdip_pkg::t_char_item in_item;
    cdip_pkg::t_char_item stage_item;
    cdip_pkg::t_result    step_result;
    cdip_pkg::t_result    out_result;
    logic                 stage_valid;
    logic                 out_free;
    logic                 advance;
    logic                 out_valid;

    assign in_item.char_code = i_char.char_code;
    assign in_item.last_char = i_char.last_char;

    // The held character moves on unless it closes a token and the result
    // register still holds an untaken result.
    assign advance = stage_valid && (!stage_item.last_char || out_free);

    cdip_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_char.valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (i_char.ready),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    // Grammar checks, accumulation and the range test for the held character.
    cdip_token u_token (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (stage_item),
        .o_result (step_result)
    );

    // A result is captured only when the closing character is consumed.
    cdip_result_reg u_result_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && stage_item.last_char),
        .i_result (step_result),
        .i_ready  (o_result.ready),
        .o_free   (out_free),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_result.valid    = out_valid;
    assign o_result.value    = out_result.value;
    assign o_result.accepted = out_result.accepted;

endmodule

>>> tb/sv/canonical_decimal_int_parser_tb.sv
// Self-checking testbench for the canonical decimal integer parser.
`timescale 1ns / 1ps

module canonical_decimal_int_parser_tb;

    // A row of the directed table: one character item, and for a closing row
    // optionally the result that can be written down straight away.
    typedef struct packed {
        logic [7:0]         ch;
        logic               last;
        logic               known;
        logic signed [31:0] val;
        logic               acc;
    } t_dir_row;

    localparam int DIR_LEN              = 23;
    localparam int RAND_CHARS_PER_PHASE = 550;
    localparam int SETTLE_CYCLES        = 8;

    // Short directed sequence. Rows whose result is obvious carry it; the
    // plain number at the end is left to the predictor.
    localparam t_dir_row DIRECTED [DIR_LEN] = '{
        // A minus sign alone carries no digit and is rejected.
        '{"-",   1'b1, 1'b1, 32'sd0, 1'b0},
        // Minus zero is not canonical.
        '{"-",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"0",   1'b1, 1'b1, 32'sd0, 1'b0},
        // A digit after a leading zero.
        '{"0",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"7",   1'b1, 1'b1, 32'sd0, 1'b0},
        // NUL, the lowest byte, is not a digit.
        '{8'h00, 1'b1, 1'b1, 32'sd0, 1'b0},
        // A minus sign that is not the first byte.
        '{"5",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"-",   1'b1, 1'b1, 32'sd0, 1'b0},
        // The highest byte.
        '{8'hFF, 1'b1, 1'b1, 32'sd0, 1'b0},
        // A lone zero is the one place a zero may lead.
        '{"0",   1'b1, 1'b1, 32'sd0, 1'b1},
        // The most negative value, whose magnitude only fits with the sign.
        '{"-",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"2",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"1",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"4",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"7",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"4",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"8",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"3",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"6",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"4",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"8",   1'b1, 1'b1, 32'sh8000_0000, 1'b1},
        // An ordinary number, checked by the predictor.
        '{"4",   1'b0, 1'b0, 32'sd0, 1'b0},
        '{"2",   1'b1, 1'b0, 32'sd0, 1'b0}
    };

    logic clk;
    logic rst_n;

    cdip_char_if   char_ch ();
    cdip_result_if res_ch ();

    canonical_decimal_int_parser i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_char   (char_ch.sink),
        .o_result (res_ch.source)
    );

    // Predictor state for the token in flight, and the results still owed
    // by the block, oldest first.
    cdip_pkg::t_token  token_st = cdip_pkg::TOKEN_CLEAR;
    cdip_pkg::t_result pending_results [$];

    // Idle percentages of the two sides; the main sequence changes them
    // between phases.
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    int chars_sent     = 0;
    int results_seen   = 0;
    int accepted_seen  = 0;
    int mismatch_cnt   = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Applies one character to the predicted token state. On a closing
    // character it reports the result that the token earns and clears the
    // state for the next token.
    task automatic parse_char(input logic [7:0] ch, input logic last,
                              output bit closes, output cdip_pkg::t_result res);
        logic [35:0] grown;
        logic [3:0]  digit;
        closes = last;
        res    = '0;
        if (token_st.at_start && ch == cdip_pkg::CHAR_MINUS) begin
            token_st.negative = 1'b1;
        end else if (ch >= cdip_pkg::CHAR_ZERO && ch <= cdip_pkg::CHAR_NINE) begin
            digit = 4'(ch - cdip_pkg::CHAR_ZERO);
            if (!token_st.seen_digit) begin
                token_st.first_digit_zero = (digit == 4'd0);
            end else if (token_st.first_digit_zero) begin
                token_st.rejected = 1'b1;
            end
            token_st.seen_digit = 1'b1;
            // Once the magnitude has run past the limit it is frozen, and
            // the overflow mark alone decides the outcome.
            if (!token_st.overflowed) begin
                grown = {4'd0, token_st.magnitude} * 36'd10 + 36'(digit);
                if (grown > 36'(cdip_pkg::MAG_LIMIT)) begin
                    token_st.overflowed = 1'b1;
                end else begin
                    token_st.magnitude = grown[31:0];
                end
            end
        end else begin
            token_st.rejected = 1'b1;
        end
        token_st.at_start = 1'b0;
        if (last) begin
            res.accepted = !token_st.rejected && !token_st.overflowed
                           && token_st.seen_digit
                           && !(token_st.negative && token_st.first_digit_zero)
                           && (token_st.magnitude < cdip_pkg::MAG_LIMIT
                               || (token_st.negative
                                   && token_st.magnitude == cdip_pkg::MAG_LIMIT));
            if (res.accepted) begin
                res.value = token_st.negative ? (32'd0 - token_st.magnitude)
                                              : token_st.magnitude;
            end
            token_st = cdip_pkg::TOKEN_CLEAR;
        end
    endtask

    // Builds one random token. Most are well formed numbers of assorted
    // sizes, with a bias towards the edge of the range and beyond it; the
    // rest carry a leading zero, a corrupted byte, a stray minus, a bare
    // sign, minus zero, or are plain noise.
    function automatic void build_token(ref logic [7:0] q[$]);
        logic [63:0] mag;
        string       digits;
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind >= 94) begin
            repeat ($urandom_range(3, 1)) q.push_back(8'($urandom_range(255)));
            return;
        end
        if (kind >= 90) begin
            q.push_back(cdip_pkg::CHAR_MINUS);
            if ($urandom_range(1) == 1) q.push_back(cdip_pkg::CHAR_ZERO);
            return;
        end
        case ($urandom_range(5))
            0:       mag = 64'($urandom_range(9));
            1:       mag = 64'($urandom_range(99999));
            2:       mag = 64'($urandom());
            3:       mag = 64'd2147483646 + 64'($urandom_range(4));
            4:       mag = {$urandom(), $urandom()} >> $urandom_range(30, 22);
            default: mag = 64'd4294967294 + 64'($urandom_range(3));
        endcase
        digits = $sformatf("%0d", mag);
        if ($urandom_range(1) == 1) q.push_back(cdip_pkg::CHAR_MINUS);
        if (kind >= 65 && kind < 75) q.push_back(cdip_pkg::CHAR_ZERO);
        for (int i = 0; i < digits.len(); i++) q.push_back(digits[i]);
        if (kind >= 75 && kind < 85) begin
            q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
        end else if (kind >= 85) begin
            q.insert($urandom_range(q.size(), 1), cdip_pkg::CHAR_MINUS);
        end
    endfunction

    // Offers one character item, entered and left at a falling edge. The
    // sender may first hold valid low, at odds set by send_gap_pct. When the item is
    // taken its result, if any, joins the queue: the typed value from the
    // table where one is given, otherwise the predicted one.
    task automatic send_char(input logic [7:0] ch, input logic last,
                             input logic known, input logic signed [31:0] tval,
                             input logic tacc);
        bit                closes;
        cdip_pkg::t_result want;
        while ($urandom_range(99) < send_gap_pct) begin
            char_ch.valid <= 1'b0;
            @(negedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= ch;
        char_ch.last_char <= last;
        @(posedge clk);
        while (!char_ch.ready) @(posedge clk);
        chars_sent++;
        parse_char(ch, last, closes, want);
        if (closes) begin
            if (known) begin
                want.value    = tval;
                want.accepted = tacc;
            end
            pending_results.push_back(want);
        end
        @(negedge clk);
    endtask

    // Holds the sender off until every result owed has been delivered.
    task automatic drain_results();
        char_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // The result side takes a fresh ready decision at every falling edge.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every delivered result is compared field by field with the oldest
    // prediction still waiting.
    always @(posedge clk) begin
        cdip_pkg::t_result want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, value %0d accepted %0b",
                         $time, res_ch.value, res_ch.accepted);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (res_ch.value !== want.value) begin
                    $display("%0t: value mismatch, expected %0d, got %0d",
                             $time, want.value, res_ch.value);
                    mismatch_cnt++;
                end
                if (res_ch.accepted !== want.accepted) begin
                    $display("%0t: accepted mismatch, expected %0b, got %0b",
                             $time, want.accepted, res_ch.accepted);
                    mismatch_cnt++;
                end
                results_seen++;
                if (want.accepted) accepted_seen++;
            end
        end
    end

    // Main sequence: reset, the directed table, then three random phases
    // with different idling on each side, each followed by a full drain.
    initial begin
        int         phase_chars;
        logic [7:0] token_bytes [$];
        char_ch.valid     = 1'b0;
        char_ch.char_code = 8'h00;
        char_ch.last_char = 1'b0;
        rst_n             = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_LEN; r++) begin
            send_char(DIRECTED[r].ch, DIRECTED[r].last, DIRECTED[r].known,
                      DIRECTED[r].val, DIRECTED[r].acc);
        end
        drain_results();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_gap_pct   = 24;
                    recv_stall_pct = 55;
                end
                1: begin
                    send_gap_pct   = 55;
                    recv_stall_pct = 24;
                end
                default: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            phase_chars = 0;
            while (phase_chars < RAND_CHARS_PER_PHASE) begin
                token_bytes.delete();
                build_token(token_bytes);
                foreach (token_bytes[i]) begin
                    send_char(token_bytes[i], i == token_bytes.size() - 1,
                              1'b0, 32'sd0, 1'b0);
                end
                phase_chars += token_bytes.size();
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d characters and %0d tokens (%0d accepted, %0d rejected).",
                 chars_sent, results_seen, accepted_seen, results_seen - accepted_seen);
        $display("Idling mixes: sender-light/receiver-heavy, the reverse, and none; %0d errors.",
                 mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("** canonical_decimal_int_parser: PASSED **");
        end else begin
            $display("** canonical_decimal_int_parser: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Timeout: %0d results still pending.", pending_results.size());
        $display("** canonical_decimal_int_parser: FAILED **");
        $finish;
    end

endmodule
